// File: hdl/pfwt_pkg.sv
// Package: shared types, constants and operation codes for the page fault tracker.
`timescale 1ns / 1ps
package pfwt_pkg;

  localparam int unsigned AddrW     = 48;
  localparam int unsigned CntW      = 31;
  localparam int unsigned MissW     = 32;
  localparam int unsigned SetW      = 11;
  localparam int unsigned PageShift = 12;
  localparam int unsigned DefMaxPages = 1024;
  localparam int unsigned DefTopCount = 5;

  localparam logic [CntW-1:0]  CntMax  = {CntW{1'b1}};
  localparam logic [MissW-1:0] MissMax = {MissW{1'b1}};
  localparam logic [SetW-1:0]  SetMax  = {SetW{1'b1}};

  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpFault = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;
  localparam logic [1:0] OpClose = 2'd3;

  localparam logic [1:0] SelTotal = 2'd0;
  localparam logic [1:0] SelRead  = 2'd1;
  localparam logic [1:0] SelWrite = 2'd2;

  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegBase = 2'd1;
  localparam logic [1:0] RegEnd  = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] fault_address;
    logic             is_write;
    logic [1:0]       list_select;
  } req_t;

  typedef struct packed {
    logic             in_window;
    logic [MissW-1:0] total_misses;
    logic [SetW-1:0]  read_set_size;
    logic [SetW-1:0]  write_set_size;
    logic [SetW-1:0]  unused_pages;
    logic             entry_valid;
    logic [2:0]       rank;
    logic [AddrW-1:0] page_address;
    logic [CntW-1:0]  page_count;
    logic             last;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;    // capture request
    logic clr_scal;    // clear counters
    logic clr_wr;      // write zeros at scan index
    logic rd;          // read tables at scan or fault index
    logic use_fault;   // address tables by fault index
    logic fault_upd;   // apply fault update from read data
    logic scan_step;   // consume read data of scan
    logic idx_clr;     // reset scan index and top list
    logic idx_inc;     // advance scan index
    logic unused_cnt;  // count untouched page
    logic unused_ld;   // load unused total
    logic emit_load;   // load output register
    logic emit_query;  // output register shows query entry
    logic rank_inc;    // advance emit rank
  } cmd_t;

  typedef struct packed {
    logic scan_done;   // scan index reached span
    logic clr_done;    // clear index reached MaxPages
    logic rank_last;   // emit rank is final
    logic out_busy;    // output register holds an unread result
  } sts_t;

endpackage

// File: hdl/pfwt_datapath.sv
// Datapath: page tables, counters, top list and output register.
`timescale 1ns / 1ps
module pfwt_datapath #(
  parameter int unsigned MaxPages = pfwt_pkg::DefMaxPages,
  parameter int unsigned TopCount = pfwt_pkg::DefTopCount
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfwt_pkg::cmd_t              cmd_i,
  output pfwt_pkg::sts_t              sts_o,
  input  pfwt_pkg::req_t              req_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [pfwt_pkg::AddrW-1:0]  cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pfwt_pkg::rsp_t              out_data_o
);
  import pfwt_pkg::*;

  localparam int unsigned IdxW  = $clog2(MaxPages);
  localparam int unsigned SpanW = IdxW + 1;
  localparam int unsigned RankW = (TopCount > 1) ? $clog2(TopCount) : 1;

  logic             mode_q;
  logic [AddrW-1:0] base_q, end_q;
  req_t             req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      base_q <= '0;
      end_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMode: mode_q <= cfg_data_i[0];
        RegBase: base_q <= cfg_data_i;
        RegEnd:  end_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
  end

  // Span in pages, capped.
  logic [AddrW-1:0] diff;
  logic [SpanW-1:0] span;
  logic [AddrW-PageShift-1:0] diff_pg;
  assign diff    = end_q - base_q;
  assign diff_pg = diff[AddrW-1:PageShift];
  always_comb begin
    if (end_q <= base_q) span = '0;
    else if (diff_pg >= (AddrW-PageShift)'(MaxPages)) span = SpanW'(MaxPages);
    else span = SpanW'(diff_pg);
  end

  // Fault index and window check.
  logic [AddrW-PageShift-1:0] fidx_full;
  logic                       f_hit;
  logic [IdxW-1:0]            fidx;
  assign fidx_full = req_q.fault_address[AddrW-1:PageShift] - base_q[AddrW-1:PageShift];
  assign fidx      = fidx_full[IdxW-1:0];
  assign f_hit = (req_q.fault_address >= base_q) && (req_q.fault_address < end_q) &&
                 (fidx_full < (AddrW-PageShift)'(span));

  // Scan index.
  logic [SpanW-1:0] sidx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sidx_q <= '0;
    else if (cmd_i.idx_clr) sidx_q <= '0;
    else if (cmd_i.idx_inc) sidx_q <= sidx_q + 1'b1;
  end
  assign sts_o.scan_done = (sidx_q >= span);
  assign sts_o.clr_done  = (sidx_q == SpanW'(MaxPages));

  // Tables.
  logic [CntW-1:0] tot_mem [MaxPages];
  logic [CntW-1:0] rd_mem  [MaxPages];
  logic [CntW-1:0] wr_mem  [MaxPages];
  logic            tch_mem [MaxPages];
  logic [CntW-1:0] tot_rd_q, rd_rd_q, wr_rd_q;
  logic            tch_rd_q;
  logic [IdxW-1:0] ra, wa, ridx_q;
  logic [CntW-1:0] tot_wd, rd_wd, wr_wd;
  logic            tot_we, rw_we, tch_we, tch_wd;

  assign ra = cmd_i.use_fault ? fidx : sidx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      tot_rd_q <= tot_mem[ra];
      rd_rd_q  <= rd_mem[ra];
      wr_rd_q  <= wr_mem[ra];
      tch_rd_q <= tch_mem[ra];
      ridx_q   <= ra;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tot_we) tot_mem[wa] <= tot_wd;
    if (rw_we) begin
      rd_mem[wa] <= rd_wd;
      wr_mem[wa] <= wr_wd;
    end
    if (tch_we) tch_mem[wa] <= tch_wd;
  end

  function automatic logic [CntW-1:0] inc_cnt(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction
  function automatic logic [SetW-1:0] inc_set(input logic [SetW-1:0] v);
    return (v == SetMax) ? v : v + 1'b1;
  endfunction

  // Counters.
  logic [MissW-1:0] miss_q;
  logic [SetW-1:0]  rset_q, wset_q, unused_q, ucnt_q;
  logic             hit_q;
  logic [SetW-1:0]  rset_n, wset_n;

  always_comb begin
    tot_we = 1'b0; rw_we = 1'b0; tch_we = 1'b0; tch_wd = 1'b0;
    wa = ridx_q; tot_wd = '0; rd_wd = rd_rd_q; wr_wd = wr_rd_q;
    rset_n = rset_q; wset_n = wset_q;
    if (cmd_i.clr_wr) begin
      wa = sidx_q[IdxW-1:0];
      tot_we = 1'b1; rw_we = 1'b1; tch_we = 1'b1;
      rd_wd = '0; wr_wd = '0;
    end else if (cmd_i.fault_upd && hit_q) begin
      tot_we = 1'b1; tch_we = 1'b1; tch_wd = 1'b1;
      tot_wd = inc_cnt(tot_rd_q);
      if (mode_q) begin
        rw_we = 1'b1;
        if (req_q.is_write) begin
          if (wr_rd_q == '0) begin
            wset_n = inc_set(wset_q);
            if (rd_rd_q != '0 && rset_q != '0) rset_n = rset_q - 1'b1;
          end
          rd_wd = '0;
          wr_wd = inc_cnt(wr_rd_q);
        end else if (wr_rd_q == '0) begin
          if (rd_rd_q == '0) rset_n = inc_set(rset_q);
          rd_wd = inc_cnt(rd_rd_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= '0; rset_q <= '0; wset_q <= '0; unused_q <= '0;
      ucnt_q <= '0; hit_q <= 1'b0;
    end else begin
      if (cmd_i.rd && cmd_i.use_fault) hit_q <= f_hit;
      if (cmd_i.clr_scal) begin
        miss_q <= '0; rset_q <= '0; wset_q <= '0; unused_q <= '0;
      end else if (cmd_i.fault_upd && hit_q) begin
        if (miss_q != MissMax) miss_q <= miss_q + 1'b1;
        rset_q <= rset_n;
        wset_q <= wset_n;
      end
      if (cmd_i.idx_clr) ucnt_q <= '0;
      else if (cmd_i.unused_cnt && !tch_rd_q) ucnt_q <= inc_set(ucnt_q);
      if (cmd_i.unused_ld && mode_q) unused_q <= ucnt_q;
    end
  end

  // Top list, sorted insert of one candidate per step.
  logic [CntW-1:0] bcnt_q [TopCount];
  logic [IdxW-1:0] bidx_q [TopCount];
  logic [CntW-1:0] cand;
  logic [TopCount-1:0] ge;
  always_comb begin
    case (req_q.list_select)
      SelTotal: cand = tot_rd_q;
      SelRead:  cand = rd_rd_q;
      SelWrite: cand = wr_rd_q;
      default:  cand = '0;
    endcase
    for (int k = 0; k < TopCount; k++) ge[k] = (cand >= bcnt_q[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TopCount; k++) begin
        bcnt_q[k] <= '0; bidx_q[k] <= '0;
      end
    end else if (cmd_i.idx_clr) begin
      for (int k = 0; k < TopCount; k++) bcnt_q[k] <= '0;
    end else if (cmd_i.scan_step && cand != '0) begin
      // Empty slots hold zero so a nonzero candidate always lands ahead of them.
      for (int k = 0; k < TopCount; k++) begin
        if (ge[k]) begin
          if (k == 0 || !ge[k-1]) begin
            bcnt_q[k] <= cand; bidx_q[k] <= ridx_q;
          end else begin
            bcnt_q[k] <= bcnt_q[k-1]; bidx_q[k] <= bidx_q[k-1];
          end
        end
      end
    end
  end

  // Output register.
  logic [RankW-1:0] rank_q;
  rsp_t             out_q, out_d;
  logic             ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rank_q <= '0;
    else if (cmd_i.idx_clr) rank_q <= '0;
    else if (cmd_i.rank_inc) rank_q <= rank_q + 1'b1;
  end
  assign sts_o.rank_last = (rank_q == RankW'(TopCount - 1));
  assign sts_o.out_busy  = ov_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.emit_load) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end

  always_comb begin
    out_d = '0;
    out_d.total_misses   = miss_q;
    out_d.read_set_size  = rset_q;
    out_d.write_set_size = wset_q;
    out_d.unused_pages   = unused_q;
    if (cmd_i.emit_query) begin
      out_d.rank = 3'(rank_q);
      out_d.last = sts_o.rank_last;
      if (bcnt_q[rank_q] != '0) begin
        out_d.entry_valid  = 1'b1;
        out_d.page_count   = bcnt_q[rank_q];
        out_d.page_address = base_q + {(AddrW-PageShift-IdxW)'(0), bidx_q[rank_q],
                                       PageShift'(0)};
      end
    end else begin
      out_d.last      = 1'b1;
      out_d.in_window = (req_q.operation == OpFault) && hit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
endmodule

// File: hdl/pfwt_ctrl.sv
// Controller: sequences start, fault, query and close over the datapath.
`timescale 1ns / 1ps
module pfwt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        op_i,
  output logic              in_stall_o,
  input  pfwt_pkg::sts_t    sts_i,
  output pfwt_pkg::cmd_t    cmd_o
);
  import pfwt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDisp  = 3'd1;
  localparam logic [2:0] StFRd   = 3'd2;
  localparam logic [2:0] StFUpd  = 3'd3;
  localparam logic [2:0] StClr   = 3'd4;
  localparam logic [2:0] StScan  = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] op_q;
  logic       pend_q, pend_d;  // read data waiting for scan consumption

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; op_q <= OpStart; pend_q <= 1'b0;
    end else begin
      state_q <= state_d; pend_q <= pend_d;
      if (state_q == StIdle && in_valid_i) op_q <= op_i;
    end
  end

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    pend_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = StDisp;
        end
      end
      StDisp: begin
        cmd_o.idx_clr = 1'b1;
        unique case (op_q)
          OpStart: begin cmd_o.clr_scal = 1'b1; state_d = StClr; end
          OpFault: begin cmd_o.rd = 1'b1; cmd_o.use_fault = 1'b1; state_d = StFRd; end
          default: state_d = StScan;
        endcase
      end
      StFRd: begin
        if (!sts_i.out_busy) begin
          cmd_o.fault_upd = 1'b1;
          state_d = StFUpd;
        end
      end
      // Report after the counters settle.
      StFUpd: begin
        cmd_o.emit_load = 1'b1;
        state_d = StIdle;
      end
      StClr: begin
        if (sts_i.clr_done) begin
          if (!sts_i.out_busy) begin
            cmd_o.emit_load = 1'b1;
            state_d = StIdle;
          end
        end else begin
          cmd_o.clr_wr  = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end
      end
      StScan: begin
        if (pend_q) begin
          cmd_o.scan_step  = (op_q == OpQuery);
          cmd_o.unused_cnt = (op_q == OpClose);
        end
        if (!sts_i.scan_done) begin
          cmd_o.rd = 1'b1; cmd_o.idx_inc = 1'b1; pend_d = 1'b1;
        end else if (!pend_q) begin
          if (op_q == OpClose) begin
            if (!sts_i.out_busy) begin
              cmd_o.unused_ld = 1'b1;
              state_d = StFUpd;
            end
          end else state_d = StEmit;
        end
      end
      StEmit: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_load  = 1'b1;
          cmd_o.emit_query = 1'b1;
          cmd_o.rank_inc   = 1'b1;
          if (sts_i.rank_last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// File: hdl/page_fault_wss_tracker_top.sv
// Top level of the page fault working-set tracker.
`timescale 1ns / 1ps
// Usage:
//   Requests arrive on in_valid_i/in_data_i and are taken when in_stall_o is
//   low. Each request yields results on out_valid_o/out_data_o, taken when
//   out_stall_i is low; the last one of a request has last set.
//   Fault: reads the table, applies the update and reports; the update waits
//   while the output is stalled. Start: clears all MAX_PAGES table entries
//   one per cycle. Query: scans the current span one page per cycle, then
//   gives TOP_COUNT results, one per cycle while the output is not stalled.
//   Close: scans the span one page per cycle.
//   One request is in work at a time; the next is accepted once the last
//   result sits in the output register.
//   Reset clears counters and configuration; tables hold garbage until a
//   start clears them. A stalled output holds its result and the controller
//   waits before loading the next.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
//   must write it only while idle, as the block itself does not enforce this.
module page_fault_wss_tracker_top #(
  parameter int unsigned MAX_PAGES = pfwt_pkg::DefMaxPages,
  parameter int unsigned TOP_COUNT = pfwt_pkg::DefTopCount
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pfwt_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pfwt_pkg::rsp_t              out_data_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [pfwt_pkg::AddrW-1:0]  cfg_data_i
);
  import pfwt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each request.
  pfwt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i,
    .op_i(in_data_i.operation), .in_stall_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  // Hold tables, counters and the output register.
  pfwt_datapath #(.MaxPages(MAX_PAGES), .TopCount(TOP_COUNT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .req_i(in_data_i),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // A new request never starts while one is held in work.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !cmd.load_req) else $error("accept while busy");
  // Never overwrite an unread result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.emit_load) else $error("result overwritten");
  // An accepted request stalls the input next cycle.
  a_stall_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("no stall after accept");
endmodule

// File: test/tb_page_fault_wss_tracker_top.sv
// Testbench for the page fault working-set tracker: random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_page_fault_wss_tracker_top;
  import pfwt_pkg::*;

  localparam int unsigned Pages = DefMaxPages;
  localparam int unsigned TopN  = DefTopCount;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  req_t             in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rsp_t             out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_idx = RegMode;
  logic [AddrW-1:0] cfg_data = '0;

  page_fault_wss_tracker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // Predictor copy of the block: configuration, page tables and counters.
  logic             mode_q;
  logic [AddrW-1:0] base_q, end_q;
  logic [CntW-1:0]  tot_cnt [Pages];
  logic [CntW-1:0]  rd_cnt  [Pages];
  logic [CntW-1:0]  wr_cnt  [Pages];
  logic             touched [Pages];
  logic [MissW-1:0] miss_q;
  logic [SetW-1:0]  rd_set_q, wr_set_q, unused_q;

  req_t pend_reqs[$];   // requests waiting to be offered
  rsp_t rsp_due[$];     // results owed by the block, oldest first
  int   fail_cnt = 0;
  int   rsp_seen = 0;
  bit   calm = 1'b0;    // suppress sender and receiver gaps in this phase

  function automatic int unsigned span_pages();
    logic [AddrW-1:0] n;
    if (end_q <= base_q) return 0;
    n = (end_q - base_q) >> PageShift;
    return (n > Pages) ? Pages : int'(n);
  endfunction

  function automatic logic [CntW-1:0] bump_cnt(logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [SetW-1:0] bump_set(logic [SetW-1:0] v);
    return (v == SetMax) ? v : v + 1'b1;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Push one result that shows the counters as they stand now.
  task automatic owe(logic win, logic vld, logic [2:0] rk, logic [AddrW-1:0] addr,
                     logic [CntW-1:0] cnt, logic lst);
    rsp_t r;
    r.in_window      = win;
    r.total_misses   = miss_q;
    r.read_set_size  = rd_set_q;
    r.write_set_size = wr_set_q;
    r.unused_pages   = unused_q;
    r.entry_valid    = vld;
    r.rank           = rk;
    r.page_address   = addr;
    r.page_count     = cnt;
    r.last           = lst;
    rsp_due.push_back(r);
  endtask

  // Apply one accepted request to the predictor and queue its results.
  task automatic track_request(req_t q);
    int unsigned      span, n, p, k, i;
    logic [63:0]      idx;
    logic [CntW-1:0]  c;
    logic             hit;
    logic [SetW-1:0]  cnt_u;
    int unsigned      bidx [TopN];
    logic [CntW-1:0]  bcnt [TopN];
    span = span_pages();
    case (q.operation)
      OpStart: begin
        for (i = 0; i < Pages; i++) begin
          tot_cnt[i] = '0; rd_cnt[i] = '0; wr_cnt[i] = '0; touched[i] = 1'b0;
        end
        miss_q = '0; rd_set_q = '0; wr_set_q = '0; unused_q = '0;
        owe(1'b0, 1'b0, 3'd0, '0, '0, 1'b1);
      end
      OpFault: begin
        hit = 1'b0;
        if (q.fault_address >= base_q && q.fault_address < end_q) begin
          idx = 64'(q.fault_address >> PageShift) - 64'(base_q >> PageShift);
          if (idx < span) begin
            hit = 1'b1;
            if (miss_q != MissMax) miss_q = miss_q + 1'b1;
            tot_cnt[idx] = bump_cnt(tot_cnt[idx]);
            touched[idx] = 1'b1;
            if (mode_q) begin
              if (q.is_write) begin
                if (wr_cnt[idx] == 0) begin
                  wr_set_q = bump_set(wr_set_q);
                  if (rd_cnt[idx] != 0 && rd_set_q > 0) rd_set_q = rd_set_q - 1'b1;
                end
                rd_cnt[idx] = '0;
                wr_cnt[idx] = bump_cnt(wr_cnt[idx]);
              end else if (wr_cnt[idx] == 0) begin
                if (rd_cnt[idx] == 0) rd_set_q = bump_set(rd_set_q);
                rd_cnt[idx] = bump_cnt(rd_cnt[idx]);
              end
            end
          end
        end
        owe(hit, 1'b0, 3'd0, '0, '0, 1'b1);
      end
      OpQuery: begin
        n = 0;
        if (q.list_select != 2'd3) begin
          for (i = 0; i < span; i++) begin
            c = (q.list_select == SelTotal) ? tot_cnt[i] :
                (q.list_select == SelRead) ? rd_cnt[i] : wr_cnt[i];
            if (c != 0) begin
              // Equal counts let the later, higher page move ahead.
              for (p = 0; p < n; p++) if (c >= bcnt[p]) break;
              if (p < TopN) begin
                if (n < TopN) n++;
                for (k = n - 1; k > p; k--) begin
                  bidx[k] = bidx[k-1]; bcnt[k] = bcnt[k-1];
                end
                bidx[p] = i; bcnt[p] = c;
              end
            end
          end
        end
        for (k = 0; k < TopN; k++) begin
          if (k < n)
            owe(1'b0, 1'b1, 3'(k), base_q + AddrW'(bidx[k]) * 4096, bcnt[k], k == TopN - 1);
          else
            owe(1'b0, 1'b0, 3'(k), '0, '0, k == TopN - 1);
        end
      end
      default: begin
        // Close only counts untouched pages in read/write mode.
        if (mode_q) begin
          cnt_u = '0;
          for (i = 0; i < span; i++) if (!touched[i]) cnt_u = bump_set(cnt_u);
          unused_q = cnt_u;
        end
        owe(1'b0, 1'b0, 3'd0, '0, '0, 1'b1);
      end
    endcase
  endtask

  // Driver: offer pending requests, hold each until taken, with random idle gaps between them.
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) track_request(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pend_reqs.size() > 0) begin
          in_data  <= pend_reqs.pop_front();
          in_valid <= 1'b1;
          send_gap <= rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, once hold off long enough to back up the block.
  int  stall_left = 0;
  bit  held = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        rsp_seen++;
        if (rsp_due.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          fail_cnt++;
        end else begin
          e = rsp_due.pop_front();
          if (e.in_window != out_data.in_window) begin
            $error("in_window exp %0h got %0h", e.in_window, out_data.in_window); fail_cnt++;
          end
          if (e.total_misses != out_data.total_misses) begin
            $error("total_misses exp %0h got %0h", e.total_misses, out_data.total_misses);
            fail_cnt++;
          end
          if (e.read_set_size != out_data.read_set_size) begin
            $error("read_set_size exp %0h got %0h", e.read_set_size, out_data.read_set_size);
            fail_cnt++;
          end
          if (e.write_set_size != out_data.write_set_size) begin
            $error("write_set_size exp %0h got %0h", e.write_set_size,
                   out_data.write_set_size);
            fail_cnt++;
          end
          if (e.unused_pages != out_data.unused_pages) begin
            $error("unused_pages exp %0h got %0h", e.unused_pages, out_data.unused_pages);
            fail_cnt++;
          end
          if (e.entry_valid != out_data.entry_valid) begin
            $error("entry_valid exp %0h got %0h", e.entry_valid, out_data.entry_valid);
            fail_cnt++;
          end
          if (e.rank != out_data.rank) begin
            $error("rank exp %0h got %0h", e.rank, out_data.rank); fail_cnt++;
          end
          if (e.page_address != out_data.page_address) begin
            $error("page_address exp %0h got %0h", e.page_address, out_data.page_address);
            fail_cnt++;
          end
          if (e.page_count != out_data.page_count) begin
            $error("page_count exp %0h got %0h", e.page_count, out_data.page_count);
            fail_cnt++;
          end
          if (e.last != out_data.last) begin
            $error("last exp %0h got %0h", e.last, out_data.last); fail_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!held && rsp_seen >= 60) begin
        // Long hold-off while the sender keeps offering requests.
        held       <= 1'b1;
        stall_left <= 400;
        out_stall  <= 1'b1;
      end else if (rand_gap() > 0) begin
        stall_left <= rand_gap();
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [AddrW-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegMode: mode_q = val[0];
      RegBase: base_q = val;
      default: end_q  = val;
    endcase
  endtask

  task automatic push_req(logic [1:0] op, logic [AddrW-1:0] addr, logic wr, logic [1:0] sel);
    req_t q;
    q.operation = op; q.fault_address = addr; q.is_write = wr; q.list_select = sel;
    pend_reqs.push_back(q);
  endtask

  // Wait until every request is taken and every result has come back.
  task automatic drain();
    do @(posedge clk_i);
    while (pend_reqs.size() != 0 || in_valid || rsp_due.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    logic [AddrW-1:0] b, a;
    int unsigned      sp;
    int               r;
    mode_q = 1'b0; base_q = '0; end_q = '0;
    miss_q = '0; rd_set_q = '0; wr_set_q = '0; unused_q = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: read-then-write promotion, window edges, every list, close.
    b = 48'h0000_1000_0000;
    write_reg(RegMode, 1);
    write_reg(RegBase, b);
    write_reg(RegEnd, b + 16 * 4096);
    push_req(OpStart, '0, 1'b0, SelTotal);
    push_req(OpFault, b, 1'b0, SelTotal);
    push_req(OpFault, b + 12, 1'b0, SelTotal);
    push_req(OpFault, b + 4095, 1'b1, SelTotal);
    push_req(OpFault, b + 4096, 1'b1, SelTotal);
    push_req(OpFault, b + 2 * 4096, 1'b0, SelTotal);
    push_req(OpFault, b + 3 * 4096, 1'b0, SelTotal);
    push_req(OpFault, b - 1, 1'b0, SelTotal);
    push_req(OpFault, b + 16 * 4096, 1'b1, SelTotal);
    push_req(OpFault, b + 16 * 4096 - 1, 1'b0, SelTotal);
    push_req(OpFault, '1, 1'b1, SelTotal);
    push_req(OpFault, '0, 1'b0, SelTotal);
    push_req(OpQuery, '0, 1'b0, SelTotal);
    push_req(OpQuery, '0, 1'b1, SelRead);
    push_req(OpQuery, '0, 1'b0, SelWrite);
    push_req(OpQuery, '1, 1'b1, 2'd3);
    push_req(OpClose, '0, 1'b0, SelTotal);
    push_req(OpFault, b + 5 * 4096, 1'b0, SelTotal);
    push_req(OpQuery, '0, 1'b0, SelTotal);
    drain();

    // Random phases, each with its own window and mode.
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 2);
      case (ph)
        3: begin b = '0; a = '1; end                      // widest span, capped
        5: begin b = 48'h0000_0040_0000; a = b; end       // empty window
        6: begin b = 48'hFFFF_FFFF_0000; a = '1; end      // top of address space
        default: begin
          b  = {$urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hF), 12'h000};
          sp = $urandom_range(2, 40);
          a  = b + sp * 4096 + $urandom_range(0, 4095);
        end
      endcase
      write_reg(RegMode, ph[0]);
      write_reg(RegBase, b);
      write_reg(RegEnd, a);
      sp = span_pages();
      push_req(OpStart, {$urandom, $urandom}, $urandom_range(0, 1), $urandom_range(0, 3));
      for (int n = 0; n < 50; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 4) != 0)
            a = b + $urandom_range(0, sp + 1) * 4096 + $urandom_range(0, 4095);
          else
            a = {$urandom, $urandom};
          push_req(OpFault, a, $urandom_range(0, 1), $urandom_range(0, 3));
        end else if (r < 86) begin
          push_req(OpQuery, {$urandom, $urandom}, $urandom_range(0, 1), $urandom_range(0, 3));
        end else if (r < 96) begin
          push_req(OpClose, {$urandom, $urandom}, $urandom_range(0, 1), $urandom_range(0, 3));
        end else begin
          push_req(OpStart, {$urandom, $urandom}, $urandom_range(0, 1), $urandom_range(0, 3));
        end
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && rsp_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/pfwt_pkg.sv
hdl/pfwt_datapath.sv
hdl/pfwt_ctrl.sv
hdl/page_fault_wss_tracker_top.sv
test/tb_page_fault_wss_tracker_top.sv
